[rtl/sle_pkg.sv]
// ----------------------------------------------------------------------------
// sle_pkg
// shared widths, command and status codes, control types for the sorted list
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_EXISTS = 3'd2,
    CMD_COUNT  = 3'd3,
    CMD_READ   = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SEQ_IDLE  = 2'd0,
    SEQ_EVAL  = 2'd1,
    SEQ_APPLY = 2'd2
  } seq_state_t;

  // sequencer strobes toward the datapath
  typedef struct packed {
    logic ready;
    logic load;
    logic capture;
    logic apply;
  } seq_ctrl_t;

  // per-cell update controls
  typedef struct packed {
    logic capture;
    logic shift_in;
    logic shift_out;
  } cell_ctrl_t;

endpackage

[rtl/sle_if.sv]
// ----------------------------------------------------------------------------
// sle_if
// valid/ready channels for command and result transactions
// ----------------------------------------------------------------------------
interface sle_in_if
  import sle_pkg::*;
();
  logic                          valid;
  logic                          ready;
  logic [2:0]                    command;
  logic signed [VALUE_WIDTH-1:0] item_value;
  logic [IDX_W-1:0]              read_index;

  modport source (output valid, output command, output item_value, output read_index,
                  input ready);
  modport sink   (input valid, input command, input item_value, input read_index,
                  output ready);
endinterface

interface sle_out_if
  import sle_pkg::*;
();
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic                          found;
  logic [CNT_W-1:0]              entry_count;
  logic signed [VALUE_WIDTH-1:0] read_value;

  modport source (output valid, output status, output found, output entry_count,
                  output read_value, input ready);
  modport sink   (input valid, input status, input found, input entry_count,
                  input read_value, output ready);
endinterface

[rtl/sle_cell.sv]
// ----------------------------------------------------------------------------
// sle_cell
// one list slot: holds an entry, compares it, shifts with its neighbors
// ----------------------------------------------------------------------------
module sle_cell
  import sle_pkg::*;
(
  input  logic                          clk,
  input  cell_ctrl_t                    ctrl,
  input  logic signed [VALUE_WIDTH-1:0] item_value,
  input  logic                          is_valid,
  input  logic                          is_tail,
  input  logic signed [VALUE_WIDTH-1:0] prev_entry,
  input  logic                          prev_gt,
  input  logic signed [VALUE_WIDTH-1:0] next_entry,
  output logic signed [VALUE_WIDTH-1:0] entry_o,
  output logic                          gt_o,
  output logic                          ge_o
);

  logic signed [VALUE_WIDTH-1:0] entry_r, entry_nxt;
  logic                          gt_r, gt_nxt;
  logic                          ge_r, ge_nxt;

  always_comb begin
    gt_nxt = gt_r;
    ge_nxt = ge_r;
    if (ctrl.capture) begin
      gt_nxt = is_valid && (entry_r > item_value);
      ge_nxt = is_valid && (entry_r >= item_value);
    end
  end

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.shift_in) begin
      // larger entries move one slot toward the tail
      if (prev_gt) begin
        entry_nxt = prev_entry;
      end else if (gt_r || is_tail) begin
        entry_nxt = item_value;
      end
    end else if (ctrl.shift_out && ge_r) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    gt_r    <= gt_nxt;
    ge_r    <= ge_nxt;
  end

  assign entry_o = entry_r;
  assign gt_o    = gt_r;
  assign ge_o    = ge_r;

endmodule

[rtl/sle_ctrl.sv]
// ----------------------------------------------------------------------------
// sle_ctrl
// command sequencer: load, compare, apply
// ----------------------------------------------------------------------------
module sle_ctrl
  import sle_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_free,
  output seq_ctrl_t seq
);

  seq_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SEQ_IDLE: begin
        if (in_valid) state_nxt = SEQ_EVAL;
      end
      SEQ_EVAL: begin
        state_nxt = SEQ_APPLY;
      end
      SEQ_APPLY: begin
        if (out_free) state_nxt = in_valid ? SEQ_EVAL : SEQ_IDLE;
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

  always_comb begin
    seq = '0;
    case (state_r)
      SEQ_IDLE: begin
        seq.ready = 1'b1;
        seq.load  = in_valid;
      end
      SEQ_EVAL: begin
        seq.capture = 1'b1;
      end
      SEQ_APPLY: begin
        seq.ready = out_free;
        seq.load  = out_free && in_valid;
        seq.apply = out_free;
      end
      default: begin
        seq = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/sorted_list_engine.sv]
// ----------------------------------------------------------------------------
// sorted_list_engine
// ascending list of signed values with insert, delete, exists, count, read
// and clear commands, one result transaction per command
// ----------------------------------------------------------------------------
// An accepted command passes a compare step, in which every cell compares
// its entry with the command value and registers the result, then an apply
// step, in which every cell updates from its own flags and its neighbors'
// (shift toward the tail on insert, toward the head on delete) and the
// result is written to the output register. A new command is accepted in the
// cycle a result is produced, so back-to-back commands need no idle step
// between; the compare-then-shift pass through the cell row sets the pace. A
// result that is not taken holds the engine in its apply step. No clearing
// pass after reset is needed: occupancy marks which cells hold entries.
// ----------------------------------------------------------------------------
module sorted_list_engine
  import sle_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  sle_in_if.sink    in_chan,
  sle_out_if.source out_chan
);

  // sequencer
  seq_ctrl_t seq;
  logic      out_free;

  sle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .out_free (out_free),
    .seq      (seq)
  );

  assign in_chan.ready = seq.ready;

  // latched command transaction (payload, no reset)
  logic [2:0]                    cmd_r, cmd_nxt;
  logic signed [VALUE_WIDTH-1:0] value_r, value_nxt;
  logic [IDX_W-1:0]              index_r, index_nxt;

  always_comb begin
    cmd_nxt   = cmd_r;
    value_nxt = value_r;
    index_nxt = index_r;
    if (seq.load) begin
      cmd_nxt   = in_chan.command;
      value_nxt = in_chan.item_value;
      index_nxt = in_chan.read_index;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    value_r <= value_nxt;
    index_r <= index_nxt;
  end

  // occupancy
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic             full;
  logic             found_any;

  assign full = (occ_r == CNT_W'(DEPTH));

  // cell row
  logic signed [VALUE_WIDTH-1:0] entry [DEPTH];
  logic [DEPTH-1:0]              gt;
  logic [DEPTH-1:0]              ge;
  logic [DEPTH-1:0]              eq;
  cell_ctrl_t                    cell_ctrl;

  assign cell_ctrl.capture   = seq.capture;
  assign cell_ctrl.shift_in  = seq.apply && (cmd_r == CMD_INSERT) && !full;
  assign cell_ctrl.shift_out = seq.apply && (cmd_r == CMD_DELETE) && found_any;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_WIDTH-1:0] prev_entry;
    logic signed [VALUE_WIDTH-1:0] next_entry;
    logic                          prev_gt;

    if (i == 0) begin : g_head
      assign prev_entry = '0;
      assign prev_gt    = 1'b0;
    end else begin : g_body
      assign prev_entry = entry[i-1];
      assign prev_gt    = gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_entry = '0;
    end else begin : g_inner
      assign next_entry = entry[i+1];
    end

    sle_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .item_value (value_r),
      .is_valid   (CNT_W'(i) < occ_r),
      .is_tail    (CNT_W'(i) == occ_r),
      .prev_entry (prev_entry),
      .prev_gt    (prev_gt),
      .next_entry (next_entry),
      .entry_o    (entry[i]),
      .gt_o       (gt[i]),
      .ge_o       (ge[i])
    );

    // equal entries sit where ge is set and gt is not
    assign eq[i] = ge[i] && !gt[i];
  end

  assign found_any = |eq;

  // result of the command being applied
  logic [1:0]                    status_nxt;
  logic                          found_nxt;
  logic signed [VALUE_WIDTH-1:0] read_nxt;
  logic                          index_ok;

  assign index_ok = ({1'b0, index_r} < occ_r);

  always_comb begin
    status_nxt = ST_OK;
    found_nxt  = 1'b0;
    read_nxt   = '0;
    occ_nxt    = occ_r;
    case (cmd_r)
      CMD_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          occ_nxt = occ_r + 1'b1;
        end
      end
      CMD_DELETE: begin
        if (found_any) begin
          found_nxt = 1'b1;
          occ_nxt   = occ_r - 1'b1;
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      CMD_EXISTS: begin
        if (found_any) begin
          found_nxt = 1'b1;
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      CMD_READ: begin
        if (index_ok) begin
          read_nxt = entry[index_r];
        end else begin
          status_nxt = ST_BAD_INDEX;
        end
      end
      CMD_CLEAR: begin
        occ_nxt = '0;
      end
      default: begin
        // count and unused codes leave the list alone
        occ_nxt = occ_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (seq.apply) begin
      occ_r <= occ_nxt;
    end
  end

  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic [1:0]                    out_status_r;
  logic                          out_found_r;
  logic [CNT_W-1:0]              out_count_r;
  logic signed [VALUE_WIDTH-1:0] out_read_r;

  assign out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (seq.apply) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (seq.apply) begin
      out_status_r <= status_nxt;
      out_found_r  <= found_nxt;
      out_count_r  <= occ_nxt;
      out_read_r   <= read_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.found       = out_found_r;
  assign out_chan.entry_count = out_count_r;
  assign out_chan.read_value  = out_read_r;

  // checks
  logic [DEPTH-1:0] order_ok;

  for (genvar i = 0; i < DEPTH; i++) begin : g_order
    if (i == 0) begin : g_first
      assign order_ok[i] = 1'b1;
    end else begin : g_rest
      assign order_ok[i] = !(CNT_W'(i) < occ_r) || (entry[i-1] <= entry[i]);
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(DEPTH))
    else $error("occupancy above list depth");

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    !seq.capture |-> &order_ok)
    else $error("held entries out of ascending order");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cell_ctrl.shift_in |=> occ_r == $past(occ_r) + 1'b1)
    else $error("insert did not grow the list by one");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cell_ctrl.shift_out |=> occ_r == $past(occ_r) - 1'b1)
    else $error("delete did not shrink the list by one");

endmodule

[tb/sv/sorted_list_engine_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_engine_tb
// Drives command transactions into the sorted list engine and checks every
// result transaction against a shadow copy of the list. The run opens with a
// directed pass over the value extremes and the error cases. Random phases
// follow that fill, drain or churn the list using small value pools, so that
// hits, duplicates and the full list all come up. Both channels idle at
// random, except in one quiet stretch on each side.
// ----------------------------------------------------------------------------
module sorted_list_engine_tb;
  import sle_pkg::*;

  // command codes the engine ignores
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  localparam int RANDOM_CMDS = 1000;
  localparam int IDLE_PCT    = 29;

  typedef struct {
    logic [2:0]                    command;
    logic signed [VALUE_WIDTH-1:0] value;
    logic [IDX_W-1:0]              index;
  } list_cmd_t;

  typedef struct {
    status_t                       status;
    logic                          found;
    logic [CNT_W-1:0]              entry_count;
    logic signed [VALUE_WIDTH-1:0] read_value;
  } list_outcome_t;

  typedef enum {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} phase_mix_t;

  logic clk;
  logic rst_n;

  sle_in_if  in_chan ();
  sle_out_if out_chan ();

  sorted_list_engine u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // shadow of the engine's list, updated at each accepted command
  logic signed [VALUE_WIDTH-1:0] shadow_list [DEPTH];
  int                            shadow_fill;

  list_cmd_t     pending_cmds [$];
  list_outcome_t awaited_outcomes [$];
  list_cmd_t     current_cmd;

  int accepted_total;
  int checked_total;
  int fail_count;
  int cmd_seen [8];
  int full_hits;
  int miss_hits;
  int bad_index_hits;

  // --------------------------------------------------------------------------
  // clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // every engine input known from time zero
  initial begin
    in_chan.valid      = 1'b0;
    in_chan.command    = CMD_COUNT;
    in_chan.item_value = '0;
    in_chan.read_index = '0;
    out_chan.ready     = 1'b0;
  end

  // --------------------------------------------------------------------------
  // next_outcome: runs one command against the shadow list and returns the
  // result transaction the engine should produce for it
  // --------------------------------------------------------------------------
  function automatic list_outcome_t next_outcome(list_cmd_t c);
    list_outcome_t r;
    int            at;
    int            hit;
    int            i;
    r.status     = ST_OK;
    r.found      = 1'b0;
    r.read_value = '0;
    hit          = -1;
    // first occurrence, shared by delete and exists
    for (i = shadow_fill - 1; i >= 0; i--) begin
      if (shadow_list[i] == c.value) hit = i;
    end
    case (c.command)
      CMD_INSERT: begin
        if (shadow_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // new value lands after any equal values
          at = 0;
          while (at < shadow_fill && shadow_list[at] <= c.value) at++;
          for (i = shadow_fill; i > at; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[at] = c.value;
          shadow_fill++;
        end
      end
      CMD_DELETE: begin
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.found = 1'b1;
          for (i = hit; i + 1 < shadow_fill; i++) shadow_list[i] = shadow_list[i+1];
          shadow_fill--;
        end
      end
      CMD_EXISTS: begin
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.found = 1'b1;
        end
      end
      CMD_READ: begin
        if (int'(c.index) < shadow_fill) begin
          r.read_value = shadow_list[c.index];
        end else begin
          r.status = ST_BAD_INDEX;
        end
      end
      CMD_CLEAR: begin
        shadow_fill = 0;
      end
      default: begin
        // count and the spare codes leave the list alone
      end
    endcase
    r.entry_count = CNT_W'(shadow_fill);
    return r;
  endfunction

  task automatic queue_cmd(logic [2:0] command, logic signed [VALUE_WIDTH-1:0] value,
                           logic [IDX_W-1:0] index);
    list_cmd_t c;
    c.command = command;
    c.value   = value;
    c.index   = index;
    pending_cmds.push_back(c);
  endtask

  // --------------------------------------------------------------------------
  // driver: presents the next pending command, predicts on acceptance
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_proc
    bit send_gap;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        awaited_outcomes.push_back(next_outcome(current_cmd));
        cmd_seen[current_cmd.command]++;
        accepted_total++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        // quiet stretch on the command side between 300 and 420 transactions
        send_gap = (accepted_total < 300 || accepted_total >= 420) &&
                   ($urandom_range(0, 99) < IDLE_PCT);
        if (pending_cmds.size() != 0 && !send_gap) begin
          current_cmd = pending_cmds.pop_front();
          in_chan.command    <= current_cmd.command;
          in_chan.item_value <= current_cmd.value;
          in_chan.read_index <= current_cmd.index;
          in_chan.valid      <= 1'b1;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: random backpressure, field-by-field check of each result
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_proc
    list_outcome_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (awaited_outcomes.size() == 0) begin
        $error("result transaction with nothing awaited: status %0d count %0d",
               out_chan.status, out_chan.entry_count);
        fail_count++;
      end else begin
        want = awaited_outcomes.pop_front();
        if (out_chan.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_chan.status);
          fail_count++;
        end
        if (out_chan.found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, out_chan.found);
          fail_count++;
        end
        if (out_chan.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", want.entry_count,
                 out_chan.entry_count);
          fail_count++;
        end
        if (out_chan.read_value !== want.read_value) begin
          $error("read_value: expected %0d, actual %0d", want.read_value,
                 out_chan.read_value);
          fail_count++;
        end
        case (want.status)
          ST_FULL:      full_hits++;
          ST_NOT_FOUND: miss_hits++;
          ST_BAD_INDEX: bad_index_hits++;
          default: begin
          end
        endcase
        checked_total++;
      end
    end
    // quiet stretch on the result side between 650 and 770 transactions
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (checked_total >= 650 && checked_total < 770) begin
      out_chan.ready <= 1'b1;
    end else begin
      out_chan.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stim_proc
    logic signed [VALUE_WIDTH-1:0] pool [8];
    phase_mix_t                    mix;
    int                            random_total;
    int                            seg;
    int                            seg_len;
    int                            k;
    int                            p;
    int                            roll;
    int                            ins_t, del_t, ex_t, cnt_t, rd_t, clr_t;
    logic [2:0]                    cmd;
    logic signed [VALUE_WIDTH-1:0] value;

    // directed: empty list errors, extremes, duplicate zero, head/tail deletes
    queue_cmd(CMD_COUNT,  32'sd0, 4'd0);
    queue_cmd(CMD_READ,   32'sd0, 4'd0);
    queue_cmd(CMD_DELETE, 32'sd7, 4'd0);
    queue_cmd(CMD_EXISTS, 32'sd7, 4'd0);
    queue_cmd(CMD_INSERT, 32'sh80000000, 4'd0);
    queue_cmd(CMD_INSERT, 32'sh7fffffff, 4'd0);
    queue_cmd(CMD_INSERT, 32'sd0, 4'd0);
    queue_cmd(CMD_INSERT, -32'sd1, 4'd0);
    queue_cmd(CMD_INSERT, 32'sd0, 4'd0);
    queue_cmd(CMD_INSERT, 32'sd1, 4'd0);
    queue_cmd(CMD_READ,   32'sd0, 4'd0);
    queue_cmd(CMD_READ,   32'sd0, 4'd5);
    queue_cmd(CMD_READ,   32'sd0, 4'd6);
    queue_cmd(CMD_READ,   32'sd0, 4'd15);
    queue_cmd(CMD_EXISTS, 32'sd0, 4'd0);
    queue_cmd(CMD_EXISTS, 32'sd2, 4'd0);
    queue_cmd(CMD_DELETE, 32'sd0, 4'd0);
    queue_cmd(CMD_DELETE, 32'sh7fffffff, 4'd0);
    queue_cmd(CMD_DELETE, 32'sh80000000, 4'd0);
    queue_cmd(CMD_SPARE_A, 32'sd5, 4'd3);
    queue_cmd(CMD_SPARE_B, -32'sd5, 4'd12);
    queue_cmd(CMD_COUNT,  32'sd0, 4'd0);
    queue_cmd(CMD_CLEAR,  32'sd0, 4'd0);
    queue_cmd(CMD_READ,   32'sd0, 4'd0);

    // random phases; values mostly from a small pool so lookups hit
    random_total = 0;
    for (seg = 0; random_total < RANDOM_CMDS; seg++) begin
      mix = (seg == 0) ? PHASE_FILL : phase_mix_t'($urandom_range(0, 2));
      case (mix)
        PHASE_FILL: begin
          ins_t = 60; del_t = 66; ex_t = 76; cnt_t = 80; rd_t = 95; clr_t = 96;
        end
        PHASE_DRAIN: begin
          ins_t = 15; del_t = 60; ex_t = 72; cnt_t = 76; rd_t = 94; clr_t = 95;
        end
        default: begin
          ins_t = 35; del_t = 60; ex_t = 72; cnt_t = 78; rd_t = 95; clr_t = 97;
        end
      endcase
      for (p = 0; p < 8; p++) begin
        case ($urandom_range(0, 3))
          0: pool[p] = $urandom;
          1: pool[p] = $signed($urandom_range(0, 8)) - 32'sd4;
          2: pool[p] = 32'sh80000000 + $urandom_range(0, 2);
          default: pool[p] = 32'sh7fffffff - $urandom_range(0, 2);
        endcase
      end
      seg_len = $urandom_range(30, 80);
      for (k = 0; k < seg_len; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < ins_t)      cmd = CMD_INSERT;
        else if (roll < del_t) cmd = CMD_DELETE;
        else if (roll < ex_t)  cmd = CMD_EXISTS;
        else if (roll < cnt_t) cmd = CMD_COUNT;
        else if (roll < rd_t)  cmd = CMD_READ;
        else if (roll < clr_t) cmd = CMD_CLEAR;
        else                   cmd = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
        value = ($urandom_range(0, 99) < 65) ? pool[3'($urandom_range(0, 7))] : $urandom;
        queue_cmd(cmd, value, IDX_W'($urandom_range(0, 15)));
        // spare codes do nothing, so they do not count toward the total
        if (cmd != CMD_SPARE_A && cmd != CMD_SPARE_B) random_total++;
      end
    end

    @(posedge rst_n);
    while (pending_cmds.size() != 0 || in_chan.valid || awaited_outcomes.size() != 0)
      @(posedge clk);
    // run on past the last result to catch stray results
    repeat (8) @(posedge clk);

    $write("covered %0d commands: %0d insert, %0d delete, %0d exists, ",
           accepted_total, cmd_seen[CMD_INSERT], cmd_seen[CMD_DELETE],
           cmd_seen[CMD_EXISTS]);
    $display("%0d count, %0d read, %0d clear, %0d spare",
             cmd_seen[CMD_COUNT], cmd_seen[CMD_READ], cmd_seen[CMD_CLEAR],
             cmd_seen[CMD_SPARE_A] + cmd_seen[CMD_SPARE_B]);
    $display("checked %0d results: %0d list full, %0d not found, %0d bad index",
             checked_total, full_hits, miss_hits, bad_index_hits);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("timeout after %0d commands accepted, %0d results checked",
             accepted_total, checked_total);
    $display("status: fail");
    $finish;
  end

endmodule
